// ===== rtl/core/uart_serial_receiver_core_macros.svh =====
// Assertion macros for the serial receiver checker file.
// No dependencies; include by bare file name.
`ifndef UART_SERIAL_RECEIVER_CORE_MACROS_SVH
`define UART_SERIAL_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RX_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RX_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/uart_rx_pkg.sv =====
// Package for the serial receiver core: frame phase type and fixed constants.
// No dependencies.
package uart_rx_pkg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_DATA  = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    // configuration port
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_BIT_TICKS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MSB_FIRST = 1'b1;

    localparam logic [CFG_DATA_W-1:0] BIT_TICKS_RESET = 16'd16;
    localparam logic [CFG_DATA_W-1:0] MIN_PERIOD      = 16'd2;

    localparam int BYTE_W = 8;

endpackage

// ===== rtl/core/uart_serial_receiver_core.sv =====
// Serial receiver core (8N1 style) with a two-entry result buffer.
// Depends on uart_rx_pkg.
//
// One line sample is taken per accepted request, one request per clock at
// full rate. From idle a low sample opens a frame; half a bit period later
// the start bit is re-checked and a high level drops the frame silently.
// DATA_BITS data bits follow, one per bit_ticks samples, then the stop bit.
// On the stop-bit sample one result leaves: the low 8 bits of the word and
// framing_error (stop bit low). Results sit in an output register backed by
// a skid register, so input keeps flowing while a result waits; in_stall
// rises only once both are full, i.e. after the downstream side has held
// off two results. Config writes land on the next clock and belong to idle
// periods. bit_ticks below 2 acts as 2, and values past the TICK_WIDTH
// counter range saturate to its maximum.
module uart_serial_receiver_core #(
    parameter int DATA_BITS  = 8,
    parameter int TICK_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [uart_rx_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [uart_rx_pkg::CFG_DATA_W-1:0]  cfg_data,
    // line sample requests
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                line_level,
    // result requests
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [uart_rx_pkg::BYTE_W-1:0]      received_byte,
    output logic                                framing_error
);
    import uart_rx_pkg::*;

    localparam int IDX_W   = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
    localparam int PER_W   = (TICK_WIDTH > CFG_DATA_W) ? TICK_WIDTH : CFG_DATA_W;
    localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(DATA_BITS - 1);
    localparam logic [PER_W-1:0] TICK_MAX = {PER_W{1'b1}} >> (PER_W - TICK_WIDTH);

    // configuration registers
    logic [CFG_DATA_W-1:0] bit_ticks_reg;
    logic                  msb_first_reg;

    // frame state
    phase_t                phase_reg, phase_next;
    logic [TICK_WIDTH-1:0] tick_reg, tick_next;
    logic [IDX_W-1:0]      bit_idx_reg, bit_idx_next;
    logic [DATA_BITS-1:0]  word_reg, word_next;

    // result buffer: output stage plus skid stage
    logic                  out_valid_reg;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic                  out_ferr_reg;
    logic                  skid_valid_reg;
    logic [BYTE_W-1:0]     skid_byte_reg;
    logic                  skid_ferr_reg;

    logic                  in_accept;
    logic                  out_pop;
    logic [PER_W-1:0]      per_wide;
    logic [TICK_WIDTH-1:0] period;
    logic [TICK_WIDTH-1:0] tick_inc;
    logic [DATA_BITS-1:0]  word_shifted;
    logic [BYTE_W+DATA_BITS-1:0] word_ext;
    logic                  res_valid;
    logic [BYTE_W-1:0]     res_byte;
    logic                  res_ferr;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_pop   = out_valid_reg && !out_stall;

    assign out_valid     = out_valid_reg;
    assign received_byte = out_byte_reg;
    assign framing_error = out_ferr_reg;

    // --- config ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_ticks_reg <= BIT_TICKS_RESET;
            msb_first_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDX_BIT_TICKS: bit_ticks_reg <= cfg_data;
                CFG_IDX_MSB_FIRST: msb_first_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective bit period, clamped to [2, counter max]
    always_comb
    begin
        per_wide = PER_W'(bit_ticks_reg);
        if (per_wide < PER_W'(MIN_PERIOD))
            per_wide = PER_W'(MIN_PERIOD);
        if (per_wide > TICK_MAX)
            per_wide = TICK_MAX;
        period = per_wide[TICK_WIDTH-1:0];
    end

    assign tick_inc = tick_reg + TICK_WIDTH'(1);

    // new sample enters the word at the end selected by msb_first
    always_comb
    begin
        if (msb_first_reg)
            word_shifted = {word_reg[DATA_BITS-2:0], line_level};
        else
            word_shifted = {line_level, word_reg[DATA_BITS-1:1]};
    end

    // --- next state ---
    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_idx_next = bit_idx_reg;
        word_next    = word_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (!line_level)
                begin
                    phase_next = PH_START;
                    tick_next  = '0;
                end
            end
            PH_START:
            begin
                tick_next = tick_inc;
                if (tick_inc >= (period >> 1))
                begin
                    tick_next = '0;
                    if (line_level)
                        phase_next = PH_IDLE;   // false start
                    else
                    begin
                        phase_next   = PH_DATA;
                        bit_idx_next = '0;
                        word_next    = '0;
                    end
                end
            end
            PH_DATA:
            begin
                tick_next = tick_inc;
                if (tick_inc >= period)
                begin
                    tick_next = '0;
                    word_next = word_shifted;
                    if (bit_idx_reg >= LAST_BIT)
                    begin
                        phase_next   = PH_STOP;
                        bit_idx_next = '0;
                    end
                    else
                        bit_idx_next = bit_idx_reg + IDX_W'(1);
                end
            end
            PH_STOP:
            begin
                tick_next = tick_inc;
                if (tick_inc >= period)
                begin
                    tick_next  = '0;
                    phase_next = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // --- result ---
    always_comb
    begin
        res_valid = in_accept && (phase_reg == PH_STOP) && (tick_inc >= period);
        word_ext  = {{BYTE_W{1'b0}}, word_reg};
        res_byte  = word_ext[BYTE_W-1:0];
        res_ferr  = !line_level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_idx_reg <= '0;
            word_reg    <= '0;
        end
        else if (in_accept)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_idx_reg <= bit_idx_next;
            word_reg    <= word_next;
        end
    end

    // --- result buffer control ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                // input is stalled; drain skid into the output stage
                if (out_pop)
                    skid_valid_reg <= 1'b0;
            end
            else if (res_valid)
            begin
                if (out_valid_reg && !out_pop)
                    skid_valid_reg <= 1'b1;
                else
                    out_valid_reg <= 1'b1;
            end
            else if (out_pop)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                out_byte_reg <= skid_byte_reg;
                out_ferr_reg <= skid_ferr_reg;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_pop)
            begin
                skid_byte_reg <= res_byte;
                skid_ferr_reg <= res_ferr;
            end
            else
            begin
                out_byte_reg <= res_byte;
                out_ferr_reg <= res_ferr;
            end
        end
    end

endmodule

// ===== rtl/core/uart_rx_checker.sv =====
// Port-level checks for the serial receiver core, bound to its top level.
// Depends on uart_rx_pkg and uart_serial_receiver_core_macros.svh.
`include "uart_serial_receiver_core_macros.svh"

module uart_rx_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [uart_rx_pkg::BYTE_W-1:0] received_byte,
    input logic                           framing_error
);
    import uart_rx_pkg::*;

    // a stalled result stays offered
    `RX_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

    // a stalled result payload holds
    `RX_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(received_byte) && $stable(framing_error), "result changed while stalled")

    // input only stalls with a result pending
    `RX_ASSERT_SAME(a_stall_full, clk, rst_n, in_stall, out_valid, "input stalled with empty output")

    // a new result always follows an accepted sample
    `RX_ASSERT_SAME(a_res_cause, clk, rst_n, $rose(out_valid), $past(in_valid && !in_stall), "result without a sample")

endmodule

bind uart_serial_receiver_core uart_rx_checker u_rx_checker (.*);

// ===== tb/uart_serial_receiver_core_tb.sv =====
// Self-checking testbench for uart_serial_receiver_core: line-sample requests in,
// received bytes and framing flags out, checked against an in-bench receiver model.
// Depends on uart_rx_pkg and the core RTL; needs no other files.
`timescale 1ns / 100ps

module uart_serial_receiver_core_tb;

    import uart_rx_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_SAMPLES = 100;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              ferr;
    } rx_frame_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   line_level = 1'b1;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [BYTE_W-1:0]      received_byte;
    logic                   framing_error;

    uart_serial_receiver_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .line_level    (line_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .received_byte (received_byte),
        .framing_error (framing_error)
    );

    // Line samples waiting to go out, and frames the model says must come back.
    logic      line_samples[$];
    rx_frame_t pending_frames[$];
    int        queued_samples = 0;
    int        error_count = 0;

    // Sender pacing: bursts of requests with gaps in between, unless steady.
    bit        steady_sender = 1'b0;
    bit        line_taken = 1'b0;
    int        burst_left = 0;
    int        gap_left = 0;

    // Receiver hold-off: a 16-bit stall pattern, re-rolled each time the 6-bit step counter wraps.
    logic [15:0] stall_pattern = '0;
    logic [5:0]  stall_step = '0;

    // Effective bit period the stimulus is built for (register value clamped).
    int        line_period = 16;

    // Receiver model: configuration copy and frame state.
    logic [CFG_DATA_W-1:0] model_bit_ticks = BIT_TICKS_RESET;
    logic                  model_msb_first = 1'b1;
    phase_t                rx_phase = PH_IDLE;
    logic [15:0]           tick_cnt = '0;
    logic [2:0]            bit_idx = '0;
    logic [BYTE_W-1:0]     shift_reg = '0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Generous cap, several times what a full run needs.
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Advance the model by one line sample. Returns 1 when the stop bit is
    // sampled, with the assembled byte and the framing flag.
    function automatic bit sample_line(input logic level, output rx_frame_t frame);
        logic [15:0] per;
        per = (model_bit_ticks < MIN_PERIOD) ? MIN_PERIOD : model_bit_ticks;
        frame = '0;
        sample_line = 1'b0;
        case (rx_phase)
            PH_IDLE:
            begin
                if (!level)
                begin
                    rx_phase = PH_START;
                    tick_cnt = '0;
                end
            end
            PH_START:
            begin
                tick_cnt = tick_cnt + 16'd1;
                // start bit re-checked at half a period (rounded down)
                if (tick_cnt >= (per >> 1))
                begin
                    tick_cnt = '0;
                    if (level)
                        rx_phase = PH_IDLE;
                    else
                    begin
                        rx_phase = PH_DATA;
                        bit_idx = '0;
                        shift_reg = '0;
                    end
                end
            end
            PH_DATA:
            begin
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= per)
                begin
                    tick_cnt = '0;
                    if (model_msb_first)
                        shift_reg = {shift_reg[BYTE_W-2:0], level};
                    else
                        shift_reg = {level, shift_reg[BYTE_W-1:1]};
                    if (bit_idx == 3'd7)
                    begin
                        rx_phase = PH_STOP;
                        bit_idx = '0;
                    end
                    else
                        bit_idx = bit_idx + 3'd1;
                end
            end
            default:
            begin
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= per)
                begin
                    tick_cnt = '0;
                    rx_phase = PH_IDLE;
                    frame.data = shift_reg;
                    frame.ferr = ~level;
                    sample_line = 1'b1;
                end
            end
        endcase
    endfunction

    // Sender: one new request per falling edge once the previous one was taken.
    // Between requests the line input carries junk, which the core must ignore.
    always @(negedge clk)
    begin : drive_line
        logic next_valid;
        logic next_level;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || line_taken)
        begin
            next_valid = 1'b0;
            next_level = 1'($urandom_range(1));
            if (gap_left > 0)
                gap_left--;
            else if (line_samples.size() > 0)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(48, 1);
                    if (!steady_sender && $urandom_range(3) != 0)
                        gap_left = $urandom_range(6, 1);
                end
                if (gap_left == 0)
                begin
                    next_valid = 1'b1;
                    next_level = line_samples.pop_front();
                    burst_left--;
                end
            end
            in_valid <= next_valid;
            line_level <= next_level;
        end
    end

    // Receiver: stall follows a pattern; an all-clear pattern now and then gives
    // stretches with no hold-off at all.
    always @(negedge clk)
    begin
        stall_step <= stall_step + 6'd1;
        if (stall_step == '0)
            stall_pattern <= ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
        out_stall <= stall_pattern[stall_step[3:0]];
    end

    // Monitor: register writes and accepted line samples feed the model; each
    // accepted result is checked against the oldest predicted frame.
    always @(posedge clk)
    begin : watch_core
        rx_frame_t predicted;
        rx_frame_t oldest;
        line_taken <= rst_n && in_valid && (in_stall === 1'b0);
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_IDX_BIT_TICKS)
                    model_bit_ticks = cfg_data;
                else if (cfg_index == CFG_IDX_MSB_FIRST)
                    model_msb_first = cfg_data[0];
            end
            if (in_valid && in_stall === 1'b0)
            begin
                if (sample_line(line_level, predicted))
                    pending_frames.push_back(predicted);
            end
            if (out_valid === 1'b1 && !out_stall)
            begin
                if (pending_frames.size() == 0)
                begin
                    $display("%0t: unexpected result byte %02h ferr %b",
                             $time, received_byte, framing_error);
                    error_count++;
                end
                else
                begin
                    oldest = pending_frames.pop_front();
                    if (received_byte !== oldest.data)
                    begin
                        $display("%0t: received_byte expected %02h got %02h",
                                 $time, oldest.data, received_byte);
                        error_count++;
                    end
                    if (framing_error !== oldest.ferr)
                    begin
                        $display("%0t: framing_error expected %b got %b",
                                 $time, oldest.ferr, framing_error);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic push_level(input logic lvl);
        line_samples.push_back(lvl);
        queued_samples++;
    endtask

    // Register write: enable high for exactly one rising edge.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_period(input logic [CFG_DATA_W-1:0] ticks);
        write_reg(CFG_IDX_BIT_TICKS, ticks);
        line_period = int'((ticks < MIN_PERIOD) ? MIN_PERIOD : ticks);
    endtask

    // One frame with the given stop level, start bit first, data LSB first on the line.
    // Samples away from the sampling points get an occasional glitch.
    task automatic push_frame(input logic [BYTE_W-1:0] data, input logic stop_level);
        int  half;
        int  last;
        int  slot;
        logic lvl;
        bit  at_sample;
        half = line_period / 2;
        last = half + 9 * line_period;
        for (int k = 0; k <= last; k++)
        begin
            slot = k / line_period;
            if (slot == 0)
                lvl = 1'b0;
            else if (slot <= 8)
                lvl = data[slot-1];
            else
                lvl = stop_level;
            at_sample = (k == 0) || (k >= half && (k - half) % line_period == 0);
            if (!at_sample && $urandom_range(15) == 0)
                lvl = ~lvl;
            push_level(lvl);
        end
        repeat ($urandom_range(3))
            push_level(1'b1);
    endtask

    // Start edge that is high again at the half-period check.
    task automatic push_false_start();
        int half;
        half = line_period / 2;
        push_level(1'b0);
        for (int k = 1; k < half; k++)
            push_level(1'($urandom_range(1)));
        push_level(1'b1);
    endtask

    // Random line noise, then enough idle level to close any frame it opened.
    task automatic push_noise(input int count);
        repeat (count)
            push_level(1'($urandom_range(1)));
        repeat (10 * line_period)
            push_level(1'b1);
    endtask

    // Wait until every request is out and every frame is back, then let the core
    // settle before the next register write.
    task automatic drain_results();
        do
            @(posedge clk);
        while (line_samples.size() != 0 || in_valid || pending_frames.size() != 0);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                    pick;
        int                    phase_start;
        logic [CFG_DATA_W-1:0] ticks;
        rst_n = 1'b0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults: 16 ticks per bit, MSB first.
        push_frame(8'hA5, 1'b1);
        drain_results();

        // Shortest legal period, all-zero / all-one bytes, bad stop, false start.
        set_period(MIN_PERIOD);
        write_reg(CFG_IDX_MSB_FIRST, 16'd1);
        push_frame(8'h00, 1'b1);
        push_frame(8'hFF, 1'b1);
        push_frame(8'h5A, 1'b0);
        push_false_start();
        push_frame(8'h81, 1'b1);
        drain_results();

        // Periods below the minimum act as the minimum; LSB first.
        set_period(16'd0);
        write_reg(CFG_IDX_MSB_FIRST, 16'd0);
        push_frame(8'h01, 1'b1);
        push_frame(8'hC3, 1'b0);
        drain_results();
        set_period(16'd1);
        push_frame(8'h80, 1'b1);
        push_false_start();
        drain_results();

        // Odd period: half period rounds down.
        set_period(16'd3);
        push_frame(8'h96, 1'b1);
        push_false_start();
        push_frame(8'h3C, 1'b0);
        drain_results();

        // Random phases: mostly short periods, mostly clean frames.
        for (int ph = 0; ph < 7; ph++)
        begin
            pick = $urandom_range(15);
            if (pick < 10)
                ticks = CFG_DATA_W'($urandom_range(6, 2));
            else if (pick < 13)
                ticks = CFG_DATA_W'($urandom_range(1) ? $urandom_range(1)
                                                      : $urandom_range(12, 7));
            else
                ticks = CFG_DATA_W'($urandom_range(24, 13));
            case ($urandom_range(2))
                0:
                begin
                    set_period(ticks);
                    write_reg(CFG_IDX_MSB_FIRST, CFG_DATA_W'($urandom_range(1)));
                end
                1: set_period(ticks);
                default: write_reg(CFG_IDX_MSB_FIRST, CFG_DATA_W'($urandom_range(1)));
            endcase
            phase_start = queued_samples;
            while (queued_samples - phase_start < PHASE_SAMPLES)
            begin
                pick = $urandom_range(19);
                if (pick < 15)
                    push_frame(BYTE_W'($urandom_range(255)), $urandom_range(7) != 0);
                else if (pick < 17)
                    push_false_start();
                else
                    push_noise($urandom_range(16, 1));
            end
            drain_results();
        end

        // Sender without gaps: a false start, then a clean and a bad-stop frame.
        steady_sender = 1'b1;
        set_period(16'd12);
        write_reg(CFG_IDX_MSB_FIRST, 16'd1);
        push_false_start();
        push_frame(BYTE_W'($urandom_range(255)), 1'b1);
        push_frame(BYTE_W'($urandom_range(255)), 1'b0);
        drain_results();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
